@@ design/cuff_pressure_measure_sequencer_unit_macros.svh @@
// Assertion helpers for the measurement sequencer.
`ifndef CUFF_PRESSURE_MEASURE_SEQUENCER_UNIT_MACROS_SVH
`define CUFF_PRESSURE_MEASURE_SEQUENCER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CPMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CPMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/cpms_pkg.sv @@
`timescale 1ns / 1ps
package cpms_pkg;

   localparam int MAX_READINGS = 1024;
   localparam int COUNT_W      = $clog2(MAX_READINGS + 1);

   localparam int PRESSURE_W  = 15;
   localparam int CMD_W       = 2;
   localparam int MODE_W      = 3;
   localparam int CAUSE_W     = 2;
   localparam int INDEX_W     = 10;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DONE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FAIL   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_WAITING  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READING  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ANALYSIS = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RESULTS  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_NO_BEAT   = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_PRESSURE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_PRESSURE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFLATION_LIMIT = 2'd2;

   localparam logic [PRESSURE_W-1:0] PEAK_PRESSURE_RESET   = 15'd15000;
   localparam logic [PRESSURE_W-1:0] END_PRESSURE_RESET    = 15'd3000;
   localparam logic [PRESSURE_W-1:0] DEFLATION_LIMIT_RESET = 15'd400;

   typedef struct packed {
      logic [PRESSURE_W-1:0] peak_pressure;
      logic [PRESSURE_W-1:0] end_pressure;
      logic [PRESSURE_W-1:0] deflation_limit;
   } cpms_cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [PRESSURE_W-1:0] pressure;
   } cpms_item_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               mode_changed;
      logic [CAUSE_W-1:0] error_cause;
      logic               slow_down;
      logic               sample_taken;
      logic [INDEX_W-1:0] sample_index;
   } cpms_result_type;

endpackage

@@ design/cpms_if.sv @@
`timescale 1ns / 1ps
interface cpms_req_if
   import cpms_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [PRESSURE_W-1:0] pressure;

   modport source (output valid, output cmd, output pressure, input ready);
   modport sink   (input valid, input cmd, input pressure, output ready);
endinterface

interface cpms_rsp_if
   import cpms_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic               mode_changed;
   logic [CAUSE_W-1:0] error_cause;
   logic               slow_down;
   logic               sample_taken;
   logic [INDEX_W-1:0] sample_index;

   modport source (output valid, output mode, output mode_changed, output error_cause,
                   output slow_down, output sample_taken, output sample_index,
                   input ready);
   modport sink   (input valid, input mode, input mode_changed, input error_cause,
                   input slow_down, input sample_taken, input sample_index,
                   output ready);
endinterface

@@ design/cpms_csr.sv @@
`timescale 1ns / 1ps
module cpms_csr
   import cpms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PRESSURE_W-1:0]  csr_wdata,
   output cpms_cfg_type           cfg
);

   cpms_cfg_type cfg_ff;
   cpms_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PEAK_PRESSURE:   cfg_in.peak_pressure   = csr_wdata;
            CSR_END_PRESSURE:    cfg_in.end_pressure    = csr_wdata;
            CSR_DEFLATION_LIMIT: cfg_in.deflation_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_pressure   <= PEAK_PRESSURE_RESET;
         cfg_ff.end_pressure    <= END_PRESSURE_RESET;
         cfg_ff.deflation_limit <= DEFLATION_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/cpms_core.sv @@
`timescale 1ns / 1ps
module cpms_core
   import cpms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  cpms_item_type   item,
   input  cpms_cfg_type    cfg,
   output cpms_result_type result
);

   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic                  peak_ff, peak_in;
   logic [PRESSURE_W-1:0] last_ff, last_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [CAUSE_W-1:0]    cause_ff, cause_in;
   logic                  slow_ff, slow_in;
   logic                  taken;
   logic [INDEX_W-1:0]    index;
   logic [PRESSURE_W:0]   floor_sum;

   assign floor_sum = {1'b0, item.pressure} + {1'b0, cfg.deflation_limit};

   always_comb begin
      mode_in  = mode_ff;
      peak_in  = peak_ff;
      last_in  = last_ff;
      count_in = count_ff;
      cause_in = cause_ff;
      slow_in  = slow_ff;
      taken    = 1'b0;
      index    = '0;
      case (item.cmd)
         CMD_BUTTON: begin
            if (mode_ff == MODE_WAITING) begin
               mode_in  = MODE_READING;
               count_in = '0;
               peak_in  = 1'b0;
               slow_in  = 1'b0;
            end else if (mode_ff != MODE_ANALYSIS) begin
               mode_in = MODE_WAITING;
            end
         end
         CMD_SAMPLE: begin
            if (mode_ff == MODE_READING) begin
               taken = 1'b1;
               index = INDEX_W'(count_ff);
               if (item.pressure >= cfg.peak_pressure) begin
                  peak_in = 1'b1;
               end else if (peak_ff && (item.pressure < cfg.end_pressure)) begin
                  mode_in = MODE_ANALYSIS;
               end
               slow_in  = peak_in && (count_ff != '0) && ({1'b0, last_ff} > floor_sum);
               last_in  = item.pressure;
               count_in = count_ff + 1'b1;
               if (count_in >= COUNT_W'(MAX_READINGS)) begin
                  count_in = COUNT_W'(MAX_READINGS);
                  mode_in  = MODE_ERROR;
                  cause_in = CAUSE_TIMEOUT;
               end
            end
         end
         CMD_DONE: begin
            if (mode_ff == MODE_ANALYSIS) begin
               mode_in = MODE_RESULTS;
            end
         end
         CMD_FAIL: begin
            if (mode_ff == MODE_ANALYSIS) begin
               mode_in  = MODE_ERROR;
               cause_in = CAUSE_NO_BEAT;
            end
         end
         default: begin
         end
      endcase
      if ((mode_ff == MODE_ERROR) && (mode_in != MODE_ERROR)) begin
         cause_in = CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAITING;
         peak_ff  <= 1'b0;
         last_ff  <= '0;
         count_ff <= '0;
         cause_ff <= CAUSE_NONE;
         slow_ff  <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         peak_ff  <= peak_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         cause_ff <= cause_in;
         slow_ff  <= slow_in;
      end
   end

   always_comb begin
      result.mode         = mode_in;
      result.mode_changed = (mode_in != mode_ff);
      result.error_cause  = (mode_in == MODE_ERROR) ? cause_in : CAUSE_NONE;
      result.slow_down    = (mode_in == MODE_READING) && slow_in;
      result.sample_taken = taken;
      result.sample_index = index;
   end

endmodule

@@ design/cuff_pressure_measure_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Cuff measurement sequencer.
// req_chan carries one command per transaction: button press, pressure
// sample, analysis done or analysis failed. rsp_chan returns exactly one
// result per command: the mode after it, whether it changed, the error
// cause, the slow-down warning and the storage index of a taken sample.
// csr_* writes the peak, end and deflation thresholds; write only while
// no command is in flight.
// A command is registered on acceptance and is then evaluated against the
// mode state and captured in the result register once that register is
// free or being read by the receiver.
// One command per cycle is sustained while rsp_chan is ready; the input
// register and the result register each hold one transaction, so a new
// command is taken while a finished result waits on the receiver.
// When rsp_chan stalls, the result holds and one more command is parked in
// the input register; req_chan.ready then drops until the receiver resumes.
// Reset returns the block to waiting mode, clears all flags and counters,
// empties both registers and restores the threshold defaults.
`include "cuff_pressure_measure_sequencer_unit_macros.svh"
module cuff_pressure_measure_sequencer_unit
   import cpms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   cpms_req_if.sink               req_chan,
   cpms_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PRESSURE_W-1:0]  csr_wdata
);

   cpms_cfg_type    cfg;
   cpms_item_type   in_item_ff;
   logic            in_valid_ff, in_valid_in;
   cpms_result_type out_result_ff;
   cpms_result_type result;
   logic            out_valid_ff, out_valid_in;
   logic            advance;
   logic            req_fire;

   cpms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cpms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.cmd      <= req_chan.cmd;
         in_item_ff.pressure <= req_chan.pressure;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.mode         = out_result_ff.mode;
   assign rsp_chan.mode_changed = out_result_ff.mode_changed;
   assign rsp_chan.error_cause  = out_result_ff.error_cause;
   assign rsp_chan.slow_down    = out_result_ff.slow_down;
   assign rsp_chan.sample_taken = out_result_ff.sample_taken;
   assign rsp_chan.sample_index = out_result_ff.sample_index;

   `CPMS_ASSERT_NOW(a_cause_only_in_error, rsp_chan.valid && (rsp_chan.mode != MODE_ERROR), rsp_chan.error_cause == CAUSE_NONE, "error cause outside error mode")
   `CPMS_ASSERT_NOW(a_slow_only_in_reading, rsp_chan.valid && rsp_chan.slow_down, rsp_chan.mode == MODE_READING, "slow-down outside reading mode")
   `CPMS_ASSERT_NOW(a_sample_mode, rsp_chan.valid && rsp_chan.sample_taken, (rsp_chan.mode == MODE_READING) || (rsp_chan.mode == MODE_ANALYSIS) || (rsp_chan.mode == MODE_ERROR), "sample taken with impossible next mode")
   `CPMS_ASSERT_NOW(a_stall_only_when_full, !req_chan.ready, in_valid_ff && out_valid_ff && !rsp_chan.ready, "input stalled with a free register")
   `CPMS_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff, "evaluated transaction lost")

endmodule
